>>> rtl/grid_a_star_path_search_macros.svh
// Assertion macros for the grid A* path search block.
// Included by every RTL file that carries concurrent assertions.
`ifndef GRID_A_STAR_PATH_SEARCH_MACROS_SVH
`define GRID_A_STAR_PATH_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define GASP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define GASP_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define GASP_ASSERT(lbl, clk, rstn, prop)
`define GASP_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/gasp_pkg.sv
// Shared types and constants for the grid A* path search block.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps
package gasp_pkg;

    localparam int GRID_DIM_DEF = 8;
    localparam int COORD_W      = 3;
    localparam int CFG_W        = 4;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

    // register indexes
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // request commands
    localparam logic CMD_MAP_WRITE = 1'b0;
    localparam logic CMD_SEARCH    = 1'b1;

    // neighbour order
    localparam logic [1:0] DIR_POS_X = 2'd0;
    localparam logic [1:0] DIR_NEG_X = 2'd1;
    localparam logic [1:0] DIR_POS_Y = 2'd2;
    localparam logic [1:0] DIR_NEG_Y = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SC_ORD,
        S_SC_COST,
        S_SC_CMP,
        S_POP,
        S_SH_RD,
        S_SH_WR,
        S_EX_RD,
        S_EX_UPD,
        S_NEXT,
        S_TR_WR,
        S_TR_NXT,
        S_EM_RD,
        S_EM_OUT,
        S_NOPATH
    } state_t;

    typedef struct packed {
        logic map_wr;
        logic capture;
        logic init;
        logic scan_begin;
        logic sc_ord;
        logic sc_cost;
        logic sc_cmp;
        logic pop;
        logic sh_rd;
        logic sh_wr;
        logic sh_done;
        logic ex_rd;
        logic ex_upd;
        logic d_step;
        logic tr_wr;
        logic tr_nxt;
        logic em_rd;
        logic em_out;
        logic nopath;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_ok;
        logic scan_more;
        logic sh_more;
        logic cur_goal;
        logic nb_cand;
        logic d_last;
        logic open_empty;
        logic at_start;
        logic k_zero;
    } ctrl_stat_t;

endpackage

>>> rtl/gasp_ctrl.sv
// Sequencing state machine for the grid A* path search.
// Depends on gasp_pkg; drives the datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
module gasp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   command,
    input  gasp_pkg::ctrl_stat_t   stat,
    output gasp_pkg::ctrl_cmd_t    cmd,
    output logic                   busy
);

    gasp_pkg::state_t state_reg;
    gasp_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gasp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gasp_pkg::S_IDLE:
            begin
                if (start && command == gasp_pkg::CMD_SEARCH)
                begin
                    state_next = stat.req_ok ? gasp_pkg::S_INIT : gasp_pkg::S_NOPATH;
                end
            end
            gasp_pkg::S_INIT:    state_next = gasp_pkg::S_SC_ORD;
            gasp_pkg::S_SC_ORD:
            begin
                state_next = stat.scan_more ? gasp_pkg::S_SC_COST : gasp_pkg::S_POP;
            end
            gasp_pkg::S_SC_COST: state_next = gasp_pkg::S_SC_CMP;
            gasp_pkg::S_SC_CMP:  state_next = gasp_pkg::S_SC_ORD;
            gasp_pkg::S_POP:     state_next = gasp_pkg::S_SH_RD;
            gasp_pkg::S_SH_RD:
            begin
                if (stat.sh_more)
                begin
                    state_next = gasp_pkg::S_SH_WR;
                end
                else
                begin
                    state_next = stat.cur_goal ? gasp_pkg::S_TR_WR : gasp_pkg::S_EX_RD;
                end
            end
            gasp_pkg::S_SH_WR:   state_next = gasp_pkg::S_SH_RD;
            gasp_pkg::S_EX_RD:
            begin
                if (stat.nb_cand)
                begin
                    state_next = gasp_pkg::S_EX_UPD;
                end
                else if (stat.d_last)
                begin
                    state_next = gasp_pkg::S_NEXT;
                end
            end
            gasp_pkg::S_EX_UPD:
            begin
                state_next = stat.d_last ? gasp_pkg::S_NEXT : gasp_pkg::S_EX_RD;
            end
            gasp_pkg::S_NEXT:
            begin
                state_next = stat.open_empty ? gasp_pkg::S_NOPATH : gasp_pkg::S_SC_ORD;
            end
            gasp_pkg::S_TR_WR:
            begin
                state_next = stat.at_start ? gasp_pkg::S_EM_RD : gasp_pkg::S_TR_NXT;
            end
            gasp_pkg::S_TR_NXT:  state_next = gasp_pkg::S_TR_WR;
            gasp_pkg::S_EM_RD:   state_next = gasp_pkg::S_EM_OUT;
            gasp_pkg::S_EM_OUT:
            begin
                state_next = stat.k_zero ? gasp_pkg::S_IDLE : gasp_pkg::S_EM_RD;
            end
            gasp_pkg::S_NOPATH:  state_next = gasp_pkg::S_IDLE;
            default:             state_next = gasp_pkg::S_IDLE;
        endcase
    end

    // command decode
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            gasp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = (command == gasp_pkg::CMD_SEARCH);
                    cmd.map_wr  = (command == gasp_pkg::CMD_MAP_WRITE);
                end
            end
            gasp_pkg::S_INIT:    cmd.init    = 1'b1;
            gasp_pkg::S_SC_ORD:  cmd.sc_ord  = 1'b1;
            gasp_pkg::S_SC_COST: cmd.sc_cost = 1'b1;
            gasp_pkg::S_SC_CMP:  cmd.sc_cmp  = 1'b1;
            gasp_pkg::S_POP:     cmd.pop     = 1'b1;
            gasp_pkg::S_SH_RD:
            begin
                cmd.sh_rd   = stat.sh_more;
                cmd.sh_done = !stat.sh_more;
            end
            gasp_pkg::S_SH_WR:   cmd.sh_wr   = 1'b1;
            gasp_pkg::S_EX_RD:
            begin
                cmd.ex_rd  = stat.nb_cand;
                cmd.d_step = !stat.nb_cand;
            end
            gasp_pkg::S_EX_UPD:
            begin
                cmd.ex_upd = 1'b1;
                cmd.d_step = 1'b1;
            end
            gasp_pkg::S_NEXT:    cmd.scan_begin = 1'b1;
            gasp_pkg::S_TR_WR:   cmd.tr_wr   = 1'b1;
            gasp_pkg::S_TR_NXT:  cmd.tr_nxt  = 1'b1;
            gasp_pkg::S_EM_RD:   cmd.em_rd   = 1'b1;
            gasp_pkg::S_EM_OUT:  cmd.em_out  = 1'b1;
            gasp_pkg::S_NOPATH:  cmd.nopath  = 1'b1;
            default:             cmd = '0;
        endcase
    end

    assign busy = (state_reg != gasp_pkg::S_IDLE);

endmodule

>>> rtl/gasp_datapath.sv
// Map, open list, cost/parent stores and path trail for the A* search.
// Depends on gasp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "grid_a_star_path_search_macros.svh"
module gasp_datapath #(
    parameter int GRID_DIM = gasp_pkg::GRID_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_idx,
    input  logic [gasp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [gasp_pkg::COORD_W-1:0]      cell_x,
    input  logic [gasp_pkg::COORD_W-1:0]      cell_y,
    input  logic                              walkable,
    input  logic [gasp_pkg::COORD_W-1:0]      start_x,
    input  logic [gasp_pkg::COORD_W-1:0]      start_y,
    input  logic [gasp_pkg::COORD_W-1:0]      goal_x,
    input  logic [gasp_pkg::COORD_W-1:0]      goal_y,
    input  gasp_pkg::ctrl_cmd_t               cmd,
    output gasp_pkg::ctrl_stat_t              stat,
    output logic                              result_valid,
    output logic [gasp_pkg::COORD_W-1:0]      step_x,
    output logic [gasp_pkg::COORD_W-1:0]      step_y,
    output logic                              found,
    output logic                              last
);

    localparam int CW    = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int AW    = 2 * CW;
    localparam int CELLS = 1 << AW;
    localparam int NW    = AW + 1;
    localparam int KW    = AW + 1;
    localparam int HW    = CW + 1;
    localparam int FW    = KW + 1;
    localparam int DW    = gasp_pkg::CFG_W;

    // configuration
    logic [DW-1:0] width_reg, height_reg, w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gasp_pkg::CFG_DIM_RESET;
            height_reg <= gasp_pkg::CFG_DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == gasp_pkg::REG_GRID_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_idx == gasp_pkg::REG_GRID_HEIGHT)
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    assign w_eff = (width_reg > DW'(GRID_DIM)) ? DW'(GRID_DIM) : width_reg;
    assign h_eff = (height_reg > DW'(GRID_DIM)) ? DW'(GRID_DIM) : height_reg;

    // search state
    logic [CW-1:0]    sx_reg, sy_reg, gx_reg, gy_reg;
    logic [NW-1:0]    cnt_reg, i_reg, n_reg;
    logic [AW-1:0]    j_reg, best_idx_reg, best_cell_reg, cur_reg, nb_reg, p_reg, k_reg;
    logic [KW-1:0]    best_g_reg, gcur_reg;
    logic [FW-1:0]    best_f_reg;
    logic [HW-1:0]    best_h_reg;
    logic [1:0]       d_reg;
    logic [CELLS-1:0] open_reg, closed_reg, wvld_reg;

    logic [AW-1:0] s_cell, g_cell;
    assign s_cell = {sy_reg, sx_reg};
    assign g_cell = {gy_reg, gx_reg};

    // memories
    logic [AW-1:0] ord_mem  [CELLS];
    logic [KW-1:0] cost_mem [CELLS];
    logic [AW-1:0] par_mem  [CELLS];
    logic          walk_mem [CELLS];
    logic [AW-1:0] tr_mem   [CELLS];
    logic [AW-1:0] ord_q, par_q, tr_q;
    logic [KW-1:0] cost_q;
    logic          walk_q;

    // map write address
    logic          map_in;
    logic [AW-1:0] map_addr;
    assign map_in   = ({1'b0, cell_x} < DW'(GRID_DIM)) && ({1'b0, cell_y} < DW'(GRID_DIM));
    assign map_addr = {cell_y[CW-1:0], cell_x[CW-1:0]};

    // request range check
    assign stat.req_ok = ({1'b0, start_x} < w_eff) && ({1'b0, start_y} < h_eff)
                      && ({1'b0, goal_x} < w_eff) && ({1'b0, goal_y} < h_eff);

    // heuristic of the scanned entry
    logic [CW-1:0] ox, oy;
    logic [HW-1:0] sc_h;
    logic [FW-1:0] sc_f;
    logic          sc_take;
    assign ox   = ord_q[CW-1:0];
    assign oy   = ord_q[AW-1:CW];
    assign sc_h = HW'((ox > gx_reg) ? ox - gx_reg : gx_reg - ox)
                + HW'((oy > gy_reg) ? oy - gy_reg : gy_reg - oy);
    assign sc_f = FW'(cost_q) + FW'(sc_h);
    assign sc_take = (i_reg == '0) || (sc_f < best_f_reg)
                  || ((sc_f == best_f_reg) && (sc_h < best_h_reg));

    // neighbour of the current cell
    logic [DW-1:0] cx_w, cy_w, nx_w, ny_w;
    logic          nb_rng;
    logic [AW-1:0] nb_c;
    always_comb
    begin
        cx_w   = DW'(cur_reg[CW-1:0]);
        cy_w   = DW'(cur_reg[AW-1:CW]);
        nx_w   = cx_w;
        ny_w   = cy_w;
        nb_rng = 1'b0;
        case (d_reg)
            gasp_pkg::DIR_POS_X:
            begin
                nx_w   = cx_w + DW'(1);
                nb_rng = (nx_w < w_eff) && (cy_w < h_eff);
            end
            gasp_pkg::DIR_NEG_X:
            begin
                nx_w   = cx_w - DW'(1);
                nb_rng = (cx_w != '0) && (nx_w < w_eff) && (cy_w < h_eff);
            end
            gasp_pkg::DIR_POS_Y:
            begin
                ny_w   = cy_w + DW'(1);
                nb_rng = (ny_w < h_eff) && (cx_w < w_eff);
            end
            default:
            begin
                ny_w   = cy_w - DW'(1);
                nb_rng = (cy_w != '0) && (ny_w < h_eff) && (cx_w < w_eff);
            end
        endcase
        nb_c = {ny_w[CW-1:0], nx_w[CW-1:0]};
    end

    assign stat.nb_cand = nb_rng && !closed_reg[nb_c];
    assign stat.d_last  = (d_reg == gasp_pkg::DIR_NEG_Y);

    // relaxation of the neighbour
    logic [KW-1:0] ng;
    logic          nb_walk, upd_wr, ins_wr;
    assign ng      = gcur_reg + KW'(1);
    assign nb_walk = walk_q && wvld_reg[nb_reg];
    assign upd_wr  = cmd.ex_upd && nb_walk && open_reg[nb_reg] && (ng < cost_q);
    assign ins_wr  = cmd.ex_upd && nb_walk && !open_reg[nb_reg] && (cnt_reg < NW'(CELLS));

    // status
    assign stat.scan_more  = (i_reg < cnt_reg);
    assign stat.sh_more    = (NW'(j_reg) + NW'(1)) < cnt_reg;
    assign stat.cur_goal   = (cur_reg == g_cell);
    assign stat.open_empty = (cnt_reg == '0);
    assign stat.at_start   = (p_reg == s_cell);
    assign stat.k_zero     = (k_reg == '0);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            i_reg      <= '0;
            n_reg      <= '0;
            d_reg      <= gasp_pkg::DIR_POS_X;
            open_reg   <= '0;
            closed_reg <= '0;
            wvld_reg   <= '0;
        end
        else
        begin
            if (cmd.map_wr && map_in)
            begin
                wvld_reg[map_addr] <= 1'b1;
            end
            if (cmd.init)
            begin
                // only the start cell is open
                open_reg   <= {{(CELLS-1){1'b0}}, 1'b1} << s_cell;
                closed_reg <= '0;
                cnt_reg    <= NW'(1);
                i_reg      <= '0;
            end
            if (cmd.scan_begin)
            begin
                i_reg <= '0;
            end
            if (cmd.sc_cmp)
            begin
                i_reg <= i_reg + NW'(1);
            end
            if (cmd.pop)
            begin
                open_reg[best_cell_reg]   <= 1'b0;
                closed_reg[best_cell_reg] <= 1'b1;
            end
            if (cmd.sh_done)
            begin
                cnt_reg <= cnt_reg - NW'(1);
                d_reg   <= gasp_pkg::DIR_POS_X;
                n_reg   <= '0;
            end
            if (cmd.d_step)
            begin
                d_reg <= d_reg + 2'd1;
            end
            if (ins_wr)
            begin
                open_reg[nb_reg] <= 1'b1;
                cnt_reg          <= cnt_reg + NW'(1);
            end
            if (cmd.tr_wr)
            begin
                n_reg <= n_reg + NW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sx_reg <= start_x[CW-1:0];
            sy_reg <= start_y[CW-1:0];
            gx_reg <= goal_x[CW-1:0];
            gy_reg <= goal_y[CW-1:0];
        end
        if (cmd.sc_cmp && sc_take)
        begin
            best_idx_reg  <= i_reg[AW-1:0];
            best_cell_reg <= ord_q;
            best_g_reg    <= cost_q;
            best_f_reg    <= sc_f;
            best_h_reg    <= sc_h;
        end
        if (cmd.pop)
        begin
            cur_reg  <= best_cell_reg;
            gcur_reg <= best_g_reg;
            j_reg    <= best_idx_reg;
        end
        if (cmd.sh_wr)
        begin
            j_reg <= j_reg + AW'(1);
        end
        if (cmd.ex_rd)
        begin
            nb_reg <= nb_c;
        end
        if (cmd.sh_done)
        begin
            p_reg <= cur_reg;
        end
        if (cmd.tr_wr)
        begin
            k_reg <= n_reg[AW-1:0];
        end
        if (cmd.tr_nxt)
        begin
            p_reg <= par_q;
        end
        if (cmd.em_out)
        begin
            k_reg <= k_reg - AW'(1);
        end
    end

    // open order store
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            ord_mem[0] <= s_cell;
        end
        else if (cmd.sh_wr)
        begin
            ord_mem[j_reg] <= ord_q;
        end
        else if (ins_wr)
        begin
            ord_mem[cnt_reg[AW-1:0]] <= nb_reg;
        end
        if (cmd.sc_ord)
        begin
            ord_q <= ord_mem[i_reg[AW-1:0]];
        end
        else if (cmd.sh_rd)
        begin
            ord_q <= ord_mem[j_reg + AW'(1)];
        end
    end

    // cost and parent stores
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            cost_mem[s_cell] <= '0;
            par_mem[s_cell]  <= s_cell;
        end
        else if (upd_wr || ins_wr)
        begin
            cost_mem[nb_reg] <= ng;
            par_mem[nb_reg]  <= cur_reg;
        end
        if (cmd.sc_cost)
        begin
            cost_q <= cost_mem[ord_q];
        end
        else if (cmd.ex_rd)
        begin
            cost_q <= cost_mem[nb_c];
        end
        if (cmd.tr_wr)
        begin
            par_q <= par_mem[p_reg];
        end
    end

    // walkability map
    always_ff @(posedge clk)
    begin
        if (cmd.map_wr && map_in)
        begin
            walk_mem[map_addr] <= walkable;
        end
        if (cmd.ex_rd)
        begin
            walk_q <= walk_mem[nb_c];
        end
    end

    // path trail, goal first
    always_ff @(posedge clk)
    begin
        if (cmd.tr_wr)
        begin
            tr_mem[n_reg[AW-1:0]] <= p_reg;
        end
        if (cmd.em_rd)
        begin
            tr_q <= tr_mem[k_reg];
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.em_out || cmd.nopath;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.em_out)
        begin
            step_x <= gasp_pkg::COORD_W'(tr_q[CW-1:0]);
            step_y <= gasp_pkg::COORD_W'(tr_q[AW-1:CW]);
            found  <= 1'b1;
            last   <= (k_reg == '0);
        end
        else if (cmd.nopath)
        begin
            step_x <= '0;
            step_y <= '0;
            found  <= 1'b0;
            last   <= 1'b1;
        end
    end

    `GASP_NEVER(a_cnt_bound, clk, rst_n, cnt_reg > NW'(CELLS))
    `GASP_ASSERT(a_nopath_last, clk, rst_n, (result_valid && !found) |-> last)
    `GASP_ASSERT(a_gap_after_last, clk, rst_n, (result_valid && last) |=> !result_valid)

endmodule

>>> rtl/grid_a_star_path_search.sv
// Top level of the grid A* path search block.
// Depends on gasp_pkg, gasp_ctrl and gasp_datapath.
//
// Usage:
//   Requests are taken when start is high and busy is low. command selects a
//   map write (cell_x, cell_y, walkable; done in the same cycle, no result,
//   busy stays low) or a search from start_x/start_y to goal_x/goal_y.
//   A search emits the path cells from start to goal, one per result_valid
//   strobe, with last on the final one; with no path one result with
//   found low and last high is given. Results cannot be held off.
//   Configuration (cfg_we, cfg_idx, cfg_wdata) sets grid width and height.
// Sequence:
//   Each expansion scans the open list entry by entry (order read, cost
//   read, compare), moves each entry after the chosen one down (read,
//   write) and tries four neighbours (read, update for a candidate); the
//   single-ported open-order store sets this pace. The path is traced from
//   goal to start into the trail, then emitted from it (read, output).
// Reset:
//   The map reads as blocked and width and height return to 8.
`timescale 1ns / 1ps
module grid_a_star_path_search #(
    parameter int GRID_DIM = gasp_pkg::GRID_DIM_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_idx,
    input  logic [gasp_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [gasp_pkg::COORD_W-1:0]      cell_x,
    input  logic [gasp_pkg::COORD_W-1:0]      cell_y,
    input  logic                              walkable,
    input  logic [gasp_pkg::COORD_W-1:0]      start_x,
    input  logic [gasp_pkg::COORD_W-1:0]      start_y,
    input  logic [gasp_pkg::COORD_W-1:0]      goal_x,
    input  logic [gasp_pkg::COORD_W-1:0]      goal_y,
    output logic                              result_valid,
    output logic [gasp_pkg::COORD_W-1:0]      step_x,
    output logic [gasp_pkg::COORD_W-1:0]      step_y,
    output logic                              found,
    output logic                              last
);

    gasp_pkg::ctrl_cmd_t  cmd;
    gasp_pkg::ctrl_stat_t stat;

    // sequencer
    gasp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // storage and arithmetic
    gasp_datapath #(
        .GRID_DIM (GRID_DIM)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .walkable     (walkable),
        .start_x      (start_x),
        .start_y      (start_y),
        .goal_x       (goal_x),
        .goal_y       (goal_y),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .step_x       (step_x),
        .step_y       (step_y),
        .found        (found),
        .last         (last)
    );

endmodule
